// ===== design/sobg3_pkg.sv =====
// Shared types and constants of the 3x3 Sobel gradient core.
package sobg3_pkg;

    localparam int MAX_WIDTH   = 1024;
    localparam int LB_AW       = $clog2(MAX_WIDTH);
    localparam int PIX_W       = 8;
    localparam int GRAD_W      = 11;
    localparam int ROW_W       = 12;
    localparam int COL_W       = 10;
    localparam int WIDTH_REG_W = 11;
    localparam int HGT_REG_W   = 12;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 12;

    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = CFG_IDX_W'(1);

    localparam logic [WIDTH_REG_W-1:0] WIDTH_RESET = WIDTH_REG_W'(640);
    localparam logic [HGT_REG_W-1:0]   HGT_RESET   = HGT_REG_W'(480);
    localparam logic [WIDTH_REG_W-1:0] WIDTH_MIN   = WIDTH_REG_W'(3);
    localparam logic [WIDTH_REG_W-1:0] WIDTH_MAX   = WIDTH_REG_W'(MAX_WIDTH);
    localparam logic [HGT_REG_W-1:0]   HGT_MIN     = HGT_REG_W'(3);

    // One line-buffer entry holds the same column of the two previous rows.
    typedef struct packed {
        logic [PIX_W-1:0] two_above;
        logic [PIX_W-1:0] above;
    } t_line_word;

endpackage

// ===== design/sobel_gradient_3x3_core.sv =====
// Sobel gradient core: an accepted pixel word passes stage 1 and the output register before its result word is valid.
// Throughput is one pixel word per cycle unless the output stalls, set by the single line-buffer
// memory that is read at the accepting edge and written back at another column when stage 1 fires.
// Interior centres produce one result word; border pixels produce none.
// Reset (synchronous, active low) clears the counters, the window, the pipeline valids
// and restores width 640 and height 480; the line-buffer memory is not cleared.
module sobel_gradient_3x3_core (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // configuration write channel
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [sobg3_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [sobg3_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    // pixel input channel
    input  logic                               i_valid,
    output logic                               o_ready,
    input  logic [sobg3_pkg::PIX_W-1:0]        i_pixel,
    // gradient output channel
    output logic                               o_valid,
    input  logic                               i_ready,
    output logic signed [sobg3_pkg::GRAD_W-1:0] o_grad_x,
    output logic signed [sobg3_pkg::GRAD_W-1:0] o_grad_y,
    output logic [sobg3_pkg::ROW_W-1:0]        o_center_row,
    output logic [sobg3_pkg::COL_W-1:0]        o_center_col,
    output logic                               o_last_of_frame
);
    import sobg3_pkg::*;

    // Configuration registers.
    logic [WIDTH_REG_W-1:0] r_img_width;
    logic [HGT_REG_W-1:0]   r_img_height;
    logic [WIDTH_REG_W-1:0] eff_width;
    logic [HGT_REG_W-1:0]   eff_height;

    // Raster position of the next pixel word.
    logic [ROW_W-1:0] r_row, n_row;
    logic [COL_W-1:0] r_col, n_col;
    logic             row_end, frame_end, acc;

    // Stage 1: the accepted pixel waits here for its line-buffer read data.
    logic             r_s1_valid;
    logic [PIX_W-1:0] r_s1_pixel;
    logic [COL_W-1:0] r_s1_col;
    logic [ROW_W-1:0] r_s1_row;
    logic             r_s1_emit;
    logic             r_s1_last;
    logic             s1_fire;

    // Line-buffer memory with registered read data.
    t_line_word r_lb_mem [MAX_WIDTH];
    t_line_word r_lb_rd;

    // Sliding window: entries 0..2 are column c-2 (top, mid, bottom), 3..5 column c-1.
    logic [PIX_W-1:0] r_win [6];

    // Output register.
    logic                     r_out_valid;
    logic signed [GRAD_W-1:0] r_gx, r_gy;
    logic [ROW_W-1:0]         r_out_row;
    logic [COL_W-1:0]         r_out_col;
    logic                     r_out_last;

    logic signed [GRAD_W:0] top_s, mid_s, bot_s;
    logic signed [GRAD_W:0] lt_s, lm_s, lb_s, ct_s, cb_s;
    logic signed [GRAD_W:0] gx_full, gy_full;

    // The configuration port never stalls; the user must write only while the core is idle (not enforced here).
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_img_width  <= WIDTH_RESET;
            r_img_height <= HGT_RESET;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_IMAGE_WIDTH:  r_img_width  <= i_cfg_data[WIDTH_REG_W-1:0];
                CFG_IMAGE_HEIGHT: r_img_height <= i_cfg_data[HGT_REG_W-1:0];
                default: ;
            endcase
        end
    end

    // Out-of-range geometry is saturated to the supported range.
    always_comb begin
        if (r_img_width < WIDTH_MIN) begin
            eff_width = WIDTH_MIN;
        end else if (r_img_width > WIDTH_MAX) begin
            eff_width = WIDTH_MAX;
        end else begin
            eff_width = r_img_width;
        end
        if (r_img_height < HGT_MIN) begin
            eff_height = HGT_MIN;
        end else begin
            eff_height = r_img_height;
        end
    end

    // A stage-1 word that makes no result leaves even while the output is stalled.
    assign s1_fire = r_s1_valid && (!r_s1_emit || !r_out_valid || i_ready);
    assign o_ready = !r_s1_valid || s1_fire;
    assign acc     = i_valid && o_ready;

    // A column at or past the effective width minus one closes its row; a row at or past the
    // effective height minus one closes the frame.
    assign row_end   = ({1'b0, r_col} + WIDTH_REG_W'(1)) >= eff_width;
    assign frame_end = row_end && (({1'b0, r_row} + (ROW_W + 1)'(1)) >= {1'b0, eff_height});

    always_comb begin
        n_row = r_row;
        n_col = r_col;
        if (row_end) begin
            n_col = '0;
            n_row = frame_end ? '0 : r_row + ROW_W'(1);
        end else begin
            n_col = r_col + COL_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row <= '0;
            r_col <= '0;
        end else if (acc) begin
            r_row <= n_row;
            r_col <= n_col;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (acc) begin
            r_s1_valid <= 1'b1;
        end else if (s1_fire) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc) begin
            r_s1_pixel <= i_pixel;
            r_s1_col   <= r_col;
            r_s1_row   <= r_row;
            r_s1_emit  <= (r_row >= ROW_W'(2)) && (r_col >= COL_W'(2));
            r_s1_last  <= frame_end;
        end
    end

    // Read at the accepting edge, write back when the word leaves stage 1. Consecutive
    // words always sit in different columns, so the read and the write in one cycle
    // never touch the same entry. The read register holds while stage 1 is stalled.
    always_ff @(posedge i_clk) begin
        if (acc) begin
            r_lb_rd <= r_lb_mem[r_col[LB_AW-1:0]];
        end
        if (s1_fire) begin
            r_lb_mem[r_s1_col[LB_AW-1:0]] <= '{two_above: r_lb_rd.above, above: r_s1_pixel};
        end
    end

    // Gradient arithmetic on the completed 3x3 neighbourhood.
    always_comb begin
        top_s   = $signed({4'b0, r_lb_rd.two_above});
        mid_s   = $signed({4'b0, r_lb_rd.above});
        bot_s   = $signed({4'b0, r_s1_pixel});
        lt_s    = $signed({4'b0, r_win[0]});
        lm_s    = $signed({4'b0, r_win[1]});
        lb_s    = $signed({4'b0, r_win[2]});
        ct_s    = $signed({4'b0, r_win[3]});
        cb_s    = $signed({4'b0, r_win[5]});
        gx_full = (top_s + (mid_s <<< 1) + bot_s) - (lt_s + (lm_s <<< 1) + lb_s);
        gy_full = (lb_s + (cb_s <<< 1) + bot_s) - (lt_s + (ct_s <<< 1) + top_s);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < 6; k++) begin
                r_win[k] <= '0;
            end
        end else if (s1_fire) begin
            r_win[0] <= r_win[3];
            r_win[1] <= r_win[4];
            r_win[2] <= r_win[5];
            r_win[3] <= r_lb_rd.two_above;
            r_win[4] <= r_lb_rd.above;
            r_win[5] <= r_s1_pixel;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_fire && r_s1_emit) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_fire && r_s1_emit) begin
            r_gx       <= gx_full[GRAD_W-1:0];
            r_gy       <= gy_full[GRAD_W-1:0];
            r_out_row  <= r_s1_row - ROW_W'(1);
            r_out_col  <= r_s1_col - COL_W'(1);
            r_out_last <= r_s1_last;
        end
    end

    assign o_valid         = r_out_valid;
    assign o_grad_x        = r_gx;
    assign o_grad_y        = r_gy;
    assign o_center_row    = r_out_row;
    assign o_center_col    = r_out_col;
    assign o_last_of_frame = r_out_last;

endmodule

// ===== tb/testbench.sv =====
// Self-checking testbench for the 3x3 Sobel gradient core, with its own window predictor.
module testbench;
    import sobg3_pkg::*;

    // A pixel word passes stage 1 and the output register; the settle margin covers a border pixel
    // that is still in flight when the last pending result has arrived.
    localparam int PIPE_LATENCY = 2;
    localparam int SETTLE_CYCLES = PIPE_LATENCY + 4;
    // The slowest correct run is roughly 2k pixel words, each held up by at most one random
    // send gap plus one output stall burst, plus a short drain before each register write.
    // The limit is several times that.
    localparam int unsigned CYCLE_LIMIT = 400_000;
    localparam int HEIGHT_CAP = 4095;
    // The index port is wider than the register file; these two indexes hold nothing.
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = CFG_IDX_W'(3);

    // One expected result word.
    typedef struct {
        logic signed [GRAD_W-1:0] grad_x;
        logic signed [GRAD_W-1:0] grad_y;
        logic [ROW_W-1:0]         center_row;
        logic [COL_W-1:0]         center_col;
        logic                     last_of_frame;
    } grad_word_t;

    logic                       i_clk;
    logic                       i_rst_n = 1'b0;
    logic                       i_cfg_valid = 1'b0;
    logic                       o_cfg_ready;
    logic [CFG_IDX_W-1:0]       i_cfg_index = '0;
    logic [CFG_DATA_W-1:0]      i_cfg_data = '0;
    logic                       i_valid = 1'b0;
    logic                       o_ready;
    logic [PIX_W-1:0]           i_pixel = '0;
    logic                       o_valid;
    logic                       i_ready = 1'b0;
    logic signed [GRAD_W-1:0]   o_grad_x;
    logic signed [GRAD_W-1:0]   o_grad_y;
    logic [ROW_W-1:0]           o_center_row;
    logic [COL_W-1:0]           o_center_col;
    logic                       o_last_of_frame;

    sobel_gradient_3x3_core dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_pixel        (i_pixel),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_grad_x       (o_grad_x),
        .o_grad_y       (o_grad_y),
        .o_center_row   (o_center_row),
        .o_center_col   (o_center_col),
        .o_last_of_frame(o_last_of_frame)
    );

    // Predictor state: the two previous rows, the two previous columns of the current
    // strip, the raster position and the geometry registers, all as after reset.
    logic [PIX_W-1:0]       line_one_up [MAX_WIDTH];
    logic [PIX_W-1:0]       line_two_up [MAX_WIDTH];
    // Entries 0..2 are the column two back (top, middle, bottom), 3..5 the column one back.
    logic [PIX_W-1:0]       strip_cols [6];
    int unsigned            row_cnt = 0;
    int unsigned            col_cnt = 0;
    logic [WIDTH_REG_W-1:0] width_reg = WIDTH_RESET;
    logic [HGT_REG_W-1:0]   height_reg = HGT_RESET;

    grad_word_t  pending_grads [$];
    int unsigned mismatch_count = 0;
    int unsigned cycle_count = 0;
    bit          idle_on = 1'b0;
    int unsigned stall_left = 0;

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // Watchdog: a hung handshake ends the run here.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("[sobel_gradient_3x3_core] ERROR");
            $finish;
        end
    end

    // Output side: ready drops in random bursts while idling is enabled.
    always @(posedge i_clk) begin
        if (!idle_on) begin
            stall_left <= 0;
            i_ready <= 1'b1;
        end else if (stall_left != 0) begin
            stall_left <= stall_left - 1;
            i_ready <= 1'b0;
        end else if ($urandom_range(0, 11) == 0) begin
            stall_left <= $urandom_range(1, 17) - 1;
            i_ready <= 1'b0;
        end else begin
            i_ready <= 1'b1;
        end
    end

    task automatic report_mismatch(input string what, input int got, input int want);
        mismatch_count++;
        $display("cycle %0d: %s got %0d, expected %0d", cycle_count, what, got, want);
    endtask

    // Every accepted result word is compared against the oldest prediction. The values
    // sampled here are the ones from just before the edge.
    always @(posedge i_clk) begin : check_results
        grad_word_t want;
        if (i_rst_n && o_valid === 1'b1 && i_ready) begin
            if (pending_grads.size() == 0) begin
                report_mismatch("unexpected result word, grad_x", o_grad_x, 0);
            end else begin
                want = pending_grads.pop_front();
                if (o_grad_x !== want.grad_x)
                    report_mismatch("grad_x", o_grad_x, want.grad_x);
                if (o_grad_y !== want.grad_y)
                    report_mismatch("grad_y", o_grad_y, want.grad_y);
                if (o_center_row !== want.center_row)
                    report_mismatch("center_row", o_center_row, want.center_row);
                if (o_center_col !== want.center_col)
                    report_mismatch("center_col", o_center_col, want.center_col);
                if (o_last_of_frame !== want.last_of_frame)
                    report_mismatch("last_of_frame", o_last_of_frame, want.last_of_frame);
            end
        end
    end

    // Register values outside the supported range saturate.
    function automatic int eff_width();
        int w;
        w = width_reg;
        if (w < WIDTH_MIN) w = WIDTH_MIN;
        if (w > MAX_WIDTH) w = MAX_WIDTH;
        return w;
    endfunction

    function automatic int eff_height();
        int h;
        h = height_reg;
        if (h < HGT_MIN) h = HGT_MIN;
        if (h > HEIGHT_CAP) h = HEIGHT_CAP;
        return h;
    endfunction

    // Pixel words still needed to close the current frame under the current geometry.
    // A column at or past the width makes the next pixel the last of its row, and a row
    // at or past the height minus one is the last row.
    function automatic int frame_pixels_left();
        int w, h, in_row, rows_after;
        w = eff_width();
        h = eff_height();
        in_row = (col_cnt >= w) ? 1 : w - col_cnt;
        rows_after = (row_cnt + 1 >= h) ? 0 : h - 1 - row_cnt;
        return in_row + rows_after * w;
    endfunction

    // Advances the window by one accepted pixel and queues the gradient it completes.
    function automatic void predict_pixel(input logic [PIX_W-1:0] px);
        int w, h, c, r, top, mid, bot, gx, gy;
        bit row_end, frame_end;
        grad_word_t g;
        w = eff_width();
        h = eff_height();
        c = col_cnt % MAX_WIDTH;
        r = row_cnt;
        bot = px;
        top = line_two_up[c];
        mid = line_one_up[c];
        row_end = (col_cnt + 1 >= w);
        frame_end = row_end && (r + 1 >= h);
        if (r >= 2 && c >= 2) begin
            gx = (top + 2 * mid + bot)
                 - (strip_cols[0] + 2 * strip_cols[1] + strip_cols[2]);
            gy = (strip_cols[2] + 2 * strip_cols[5] + bot)
                 - (strip_cols[0] + 2 * strip_cols[3] + top);
            g.grad_x = GRAD_W'(gx);
            g.grad_y = GRAD_W'(gy);
            g.center_row = ROW_W'(r - 1);
            g.center_col = COL_W'(c - 1);
            g.last_of_frame = frame_end;
            pending_grads.push_back(g);
        end
        strip_cols[0] = strip_cols[3];
        strip_cols[1] = strip_cols[4];
        strip_cols[2] = strip_cols[5];
        strip_cols[3] = PIX_W'(top);
        strip_cols[4] = PIX_W'(mid);
        strip_cols[5] = px;
        line_two_up[c] = PIX_W'(mid);
        line_one_up[c] = px;
        if (row_end) begin
            col_cnt = 0;
            row_cnt = frame_end ? 0 : r + 1;
        end else begin
            col_cnt++;
        end
    endfunction

    // Sends one pixel word, sometimes after a random gap when idling is on, and predicts it once
    // accepted. Valid stays high into the next call unless a gap or a drain lowers it.
    task automatic send_pixel(input logic [PIX_W-1:0] px);
        int gap;
        if (idle_on && $urandom_range(0, 7) == 0) begin
            gap = $urandom_range(1, 17);
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_pixel <= px;
        do @(posedge i_clk); while (!o_ready);
        predict_pixel(px);
    endtask

    task automatic send_run(input int n, input bit extreme);
        repeat (n) begin
            if (extreme) send_pixel($urandom_range(0, 1) ? 8'hFF : 8'h00);
            else send_pixel(PIX_W'($urandom_range(0, 255)));
        end
    endtask

    // Lets the pipeline empty: all predicted results out, then a quiet settle period.
    task automatic drain_pipeline();
        i_valid <= 1'b0;
        while (pending_grads.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Register writes only ever happen with the block drained.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        drain_pipeline();
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        if (idx == CFG_IMAGE_WIDTH) width_reg = data[WIDTH_REG_W-1:0];
        else if (idx == CFG_IMAGE_HEIGHT) height_reg = data;
    endtask

    function automatic logic [CFG_DATA_W-1:0] pick_width();
        case ($urandom_range(0, 9))
            0: return CFG_DATA_W'($urandom_range(0, 2));
            1: return CFG_DATA_W'($urandom_range(11, 40));
            default: return CFG_DATA_W'($urandom_range(3, 10));
        endcase
    endfunction

    function automatic logic [CFG_DATA_W-1:0] pick_height();
        case ($urandom_range(0, 9))
            0: return CFG_DATA_W'($urandom_range(0, 2));
            1: return CFG_DATA_W'($urandom_range(7, 9));
            default: return CFG_DATA_W'($urandom_range(3, 6));
        endcase
    endfunction

    // Reset geometry is 640 by 480: a full first row plus a few pixels of the second.
    // Then the geometry shrinks mid-frame, so the next pixel, sitting past the new
    // width, closes the second row, and the three-pixel row after it is the last row
    // of the frame and gives one result word centered on row one.
    task automatic test_reset_geometry();
        idle_on = 1'b1;
        send_run(640 + 4, 1'b0);
        write_reg(CFG_IMAGE_WIDTH, CFG_DATA_W'(3));
        write_reg(CFG_IMAGE_HEIGHT, CFG_DATA_W'(3));
        send_run(1 + 3, 1'b0);
    endtask

    // Full-scale gradients of both signs, saturation of too-small registers, the width
    // field dropping data bit 11, and writes to the unused indexes.
    task automatic test_directed_extremes();
        idle_on = 1'b0;
        // Width data 0x804 keeps only 4; height 0 saturates to 3. Columns 0,255,255,0 give
        // grad_x of +1020 and then -1020.
        write_reg(CFG_IMAGE_WIDTH, 12'h804);
        write_reg(CFG_IMAGE_HEIGHT, 12'h000);
        repeat (3) begin
            send_pixel(8'h00);
            send_pixel(8'hFF);
            send_pixel(8'hFF);
            send_pixel(8'h00);
        end
        write_reg(CFG_SPARE_LO, CFG_DATA_W'($urandom_range(0, 4095)));
        write_reg(CFG_SPARE_HI, CFG_DATA_W'($urandom_range(0, 4095)));
        // Width 1 saturates to 3. Rows 255,0,0,255 give grad_y of -1020 and then +1020.
        write_reg(CFG_IMAGE_WIDTH, CFG_DATA_W'(1));
        write_reg(CFG_IMAGE_HEIGHT, CFG_DATA_W'(4));
        for (int r = 0; r < 4; r++) begin
            repeat (3) send_pixel((r == 0 || r == 3) ? 8'hFF : 8'h00);
        end
    endtask

    // Random frames: mostly complete frames with random content, some cut short.
    // The width may only grow at a frame start; inside a frame the line buffers beyond
    // the current width hold nothing usable, so there it only shrinks.
    task automatic random_frames(input int n_items, input bit allow_idle);
        int sent, count;
        bit extreme;
        sent = 0;
        while (sent < n_items) begin
            idle_on = allow_idle && ($urandom_range(0, 3) != 0);
            if (row_cnt == 0 && col_cnt == 0) begin
                if ($urandom_range(0, 1) == 0) begin
                    write_reg(CFG_IMAGE_WIDTH, pick_width());
                    write_reg(CFG_IMAGE_HEIGHT, pick_height());
                end
            end else if ($urandom_range(0, 3) == 0) begin
                case ($urandom_range(0, 2))
                    0: write_reg(CFG_IMAGE_WIDTH, CFG_DATA_W'($urandom_range(0, eff_width())));
                    1: write_reg(CFG_IMAGE_HEIGHT, pick_height());
                    default: begin
                        write_reg(CFG_IMAGE_HEIGHT, pick_height());
                        write_reg(CFG_IMAGE_WIDTH, CFG_DATA_W'($urandom_range(0, eff_width())));
                    end
                endcase
            end
            if ($urandom_range(0, 4) != 0) count = frame_pixels_left();
            else count = $urandom_range(1, 2 * eff_width() + 3);
            extreme = ($urandom_range(0, 5) == 0);
            send_run(count, extreme);
            sent += count;
        end
    endtask

    // Closing stretch at full rate on both sides.
    task automatic test_steady_stream();
        random_frames(150, 1'b0);
        idle_on = 1'b0;
    endtask

    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_reset_geometry();
        test_directed_extremes();
        random_frames(520, 1'b1);
        test_steady_stream();
        // Waits for every prediction to be matched; one that never is ends in the watchdog.
        drain_pipeline();
        if (mismatch_count == 0) begin
            $display("[sobel_gradient_3x3_core] OK");
        end else begin
            $display("[sobel_gradient_3x3_core] ERROR");
        end
        $finish;
    end

endmodule
